/* design/deq_pkg.sv */
// Shared constants, codes and control structures for the double-ended queue.
// Used by every module of the design folder except deq_ram; depends on nothing.
package deq_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int DATA_W     = 32;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // an input transaction is taken this cycle
        logic load_read;  // the RAM read data is captured as the popped value
    } deq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_read; // the offered operation is a pop on a non-empty queue
    } deq_stat_t;

endpackage

/* design/deq_ram.sv */
// Generic simple dual-port RAM: one write port and one read port with registered data.
// Stand-alone; no package dependency.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/deq_ctrl.sv */
// Controller of the double-ended queue: handshakes, read wait state and result valid.
// Depends on deq_pkg for the command and status structures.
module deq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  deq_pkg::deq_stat_t stat,
    output deq_pkg::deq_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;
    logic load_direct;

    // A new transaction is taken only when no pop is in flight and the result
    // register is empty or being emptied in this cycle.
    assign in_ready    = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept      = in_valid && in_ready;
    assign load_direct = accept && !stat.needs_read;

    assign cmd.accept    = accept;
    assign cmd.load_read = (state_reg == S_READ);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && stat.needs_read)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_direct || cmd.load_read)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* design/deq_datapath.sv */
// Datapath of the double-ended queue: front index, count, ring RAM and result register.
// Depends on deq_pkg and instantiates deq_ram.
module deq_datapath #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [deq_pkg::OP_W-1:0]         op,
    input  logic signed [deq_pkg::DATA_W-1:0] push_value,
    input  deq_pkg::deq_cmd_t                cmd,
    output deq_pkg::deq_stat_t               stat,
    output logic signed [deq_pkg::DATA_W-1:0] pop_value,
    output logic [deq_pkg::STATUS_W-1:0]     status,
    output logic [deq_pkg::OCC_W-1:0]        occupancy
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW:0]   CAP_S    = (CW+1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    logic [IW-1:0] front_reg;
    logic [IW-1:0] front_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic signed [deq_pkg::DATA_W-1:0] pop_value_reg;
    logic [deq_pkg::STATUS_W-1:0]      status_reg;
    logic [deq_pkg::STATUS_W-1:0]      status_next;
    logic [deq_pkg::OCC_W-1:0]         occ_reg;

    logic          is_push;
    logic          full;
    logic          empty;
    logic [CW:0]   sum_back;
    logic [CW:0]   sum_last;
    logic [CW:0]   sum_inc;
    logic [IW-1:0] back_slot;
    logic [IW-1:0] last_slot;
    logic [IW-1:0] front_inc;
    logic [IW-1:0] front_dec;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_raddr;
    logic [deq_pkg::DATA_W-1:0] ram_rdata;

    assign is_push = (op == deq_pkg::OP_PUSH_FRONT) || (op == deq_pkg::OP_PUSH_BACK);
    assign full    = (count_reg == CAP_C);
    assign empty   = (count_reg == '0);

    assign stat.needs_read = !is_push && !empty;

    // Ring positions: each sum stays below twice the capacity, so one
    // compare and subtract wraps it.
    assign sum_back = (CW+1)'(front_reg) + (CW+1)'(count_reg);
    assign sum_last = sum_back - (CW+1)'(1);
    assign sum_inc  = (CW+1)'(front_reg) + (CW+1)'(1);

    assign back_slot = (sum_back >= CAP_S) ? IW'(sum_back - CAP_S) : IW'(sum_back);
    assign last_slot = (sum_last >= CAP_S) ? IW'(sum_last - CAP_S) : IW'(sum_last);
    assign front_inc = (sum_inc >= CAP_S)  ? IW'(sum_inc - CAP_S)  : IW'(sum_inc);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IW'(1);

    assign ram_we    = cmd.accept && is_push && !full;
    assign ram_waddr = (op == deq_pkg::OP_PUSH_FRONT) ? front_dec : back_slot;
    assign ram_raddr = (op == deq_pkg::OP_POP_FRONT) ? front_reg : last_slot;

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = deq_pkg::ST_OK;
        case (op)
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            deq_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    front_next = front_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_next = deq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Result register: filled at acceptance; a successful pop overwrites the
    // value in the following cycle with the RAM read data.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pop_value_reg <= '0;
            status_reg    <= status_next;
            occ_reg       <= deq_pkg::OCC_W'(count_next);
        end
        else if (cmd.load_read)
        begin
            pop_value_reg <= ram_rdata;
        end
    end

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_value),
        .re    (cmd.accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

endmodule

/* design/double_ended_queue.sv */
// A push, a push on a full queue or a pop on an empty queue shows its result in the cycle
// after acceptance; a successful pop shows it once the RAM read data is loaded in the read wait state.
// Pushes and error transactions are taken one per cycle while the result is taken at once;
// a successful pop holds off new transactions in its read wait state, since only one is held at a time.
// Reset (rst_n, asynchronous, active low) empties the queue and the result stage; the
// entry RAM is not cleared, as the read data of a slot is used only after it has been written.
module double_ended_queue #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, from bit 0 up: op [1:0], push_value [33:2], zero padding [39:34].
    input  logic [deq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, from bit 0 up: pop_value [31:0], status [33:32], occupancy [38:34],
    // zero padding [39].
    output logic [deq_pkg::M_TDATA_W-1:0]   m_tdata
);

    deq_pkg::deq_cmd_t  cmd;
    deq_pkg::deq_stat_t stat;

    logic [deq_pkg::OP_W-1:0]          op;
    logic signed [deq_pkg::DATA_W-1:0] push_value;
    logic signed [deq_pkg::DATA_W-1:0] pop_value;
    logic [deq_pkg::STATUS_W-1:0]      status;
    logic [deq_pkg::OCC_W-1:0]         occupancy;

    // Unpack the incoming transaction.
    assign op         = s_tdata[deq_pkg::OP_W-1:0];
    assign push_value = s_tdata[deq_pkg::OP_W +: deq_pkg::DATA_W];

    // The controller owns the handshakes and the wait state for a pop's
    // read data; the datapath owns the ring pointers, the RAM and the result.
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    deq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .push_value (push_value),
        .cmd        (cmd),
        .stat       (stat),
        .pop_value  (pop_value),
        .status     (status),
        .occupancy  (occupancy)
    );

    // Pack the result transaction, the spare top bit held at zero.
    assign m_tdata = {1'b0, occupancy, status, pop_value};

endmodule

/* design/deq_checker.sv */
// Port-level assertions for the double-ended queue, bound to its top level.
// Depends on deq_pkg for the operation and status codes.
module deq_checker #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEFAULT
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [deq_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [deq_pkg::M_TDATA_W-1:0] m_tdata
);

    // A result that is not taken stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or withdrawn while stalled");

    // Error results never carry a value.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] != deq_pkg::ST_OK) |-> (m_tdata[31:0] == '0))
        else $error("error result with non-zero value");

    // Occupancy never exceeds the capacity where the field can show it.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (CAPACITY > 31) || (int'(m_tdata[38:34]) <= CAPACITY))
        else $error("occupancy beyond capacity");

    // A push produces its result in the very next cycle.
    a_push_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && ((s_tdata[1:0] == deq_pkg::OP_PUSH_FRONT) ||
        (s_tdata[1:0] == deq_pkg::OP_PUSH_BACK)) |=> m_tvalid)
        else $error("push result late");

    // A push never reports an empty queue.
    a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && ((s_tdata[1:0] == deq_pkg::OP_PUSH_FRONT) ||
        (s_tdata[1:0] == deq_pkg::OP_PUSH_BACK)) |=> (m_tdata[33:32] != deq_pkg::ST_EMPTY))
        else $error("push reported an empty queue");

endmodule

bind double_ended_queue deq_checker #(
    .CAPACITY (CAPACITY)
) u_deq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
